// ===== src/aes128_block_cipher_assert.svh =====
// Assertion macros for the AES-128 block cipher.
// Included by the top level; no other dependencies.
`ifndef AES128_BLOCK_CIPHER_ASSERT_SVH
`define AES128_BLOCK_CIPHER_ASSERT_SVH
`define AES_ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define AES_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition");
`endif

// ===== src/aes_pkg.sv =====
// Package for the AES-128 block cipher: types, constants and byte functions.
// No dependencies.
`timescale 1ns / 1ps
package aes_pkg;
  localparam int unsigned Rounds = 10;
  localparam int unsigned KeyWords = 4 * (Rounds + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_RUN
  } state_e;

  typedef logic [7:0] byte_t;

  function automatic byte_t xtime(byte_t a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t gmul(byte_t a, byte_t b);
    byte_t r;
    byte_t p;
    r = 8'h00;
    p = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ p;
      p = xtime(p);
    end
    gmul = r;
  endfunction

  function automatic byte_t ginv(byte_t x);
    byte_t r;
    byte_t p;
    r = 8'h01;
    p = x;
    for (int i = 1; i < 8; i++) begin
      p = gmul(p, p);
      r = gmul(r, p);
    end
    ginv = r;
  endfunction

  function automatic byte_t rotl(byte_t x, int n);
    rotl = byte_t'((x << n) | (x >> (8 - n)));
  endfunction

  function automatic byte_t sbox_calc(byte_t x);
    byte_t v;
    v = ginv(x);
    sbox_calc = v ^ rotl(v, 1) ^ rotl(v, 2) ^ rotl(v, 3) ^ rotl(v, 4) ^ 8'h63;
  endfunction

  function automatic byte_t inv_sbox_calc(byte_t y);
    inv_sbox_calc = ginv(rotl(y, 1) ^ rotl(y, 3) ^ rotl(y, 6) ^ 8'h05);
  endfunction

  typedef byte_t sbox_table_t [256];

  function automatic sbox_table_t make_sbox(logic inv);
    sbox_table_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inv ? inv_sbox_calc(byte_t'(i)) : sbox_calc(byte_t'(i));
    end
    make_sbox = t;
  endfunction

  localparam sbox_table_t SboxFwd = make_sbox(1'b0);
  localparam sbox_table_t SboxInv = make_sbox(1'b1);

  function automatic logic [31:0] sub_word(logic [31:0] w);
    sub_word = {SboxFwd[w[31:24]], SboxFwd[w[23:16]], SboxFwd[w[15:8]], SboxFwd[w[7:0]]};
  endfunction
endpackage

// ===== src/aes_ram.sv =====
// Generic single-port-write RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module aes_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 22
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== src/aes_round.sv =====
// One AES round, forward or inverse, shared over all rounds of an item.
// Depends on aes_pkg.
`timescale 1ns / 1ps
module aes_round
  import aes_pkg::*;
(
  input  logic [127:0] state_i,
  input  logic [127:0] key_i,
  input  logic         inv_i,
  input  logic         first_i,
  input  logic         last_i,
  output logic [127:0] state_o
);
  byte_t s [16];
  byte_t t [16];
  byte_t m [16];
  byte_t k [16];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_i[127-8*i -: 8];
      k[i] = key_i[127-8*i -: 8];
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (inv_i) begin
          t[r + 4*((c + r) % 4)] = SboxInv[s[r + 4*c]];
        end else begin
          t[r + 4*c] = SboxFwd[s[r + 4*((c + r) % 4)]];
        end
      end
    end
    if (inv_i && !last_i) begin
      for (int i = 0; i < 16; i++) t[i] = t[i] ^ k[i];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv_i) begin
          m[r + 4*c] = gmul(8'h0e, t[4*c + r]) ^ gmul(8'h0b, t[4*c + (r+1)%4])
                     ^ gmul(8'h0d, t[4*c + (r+2)%4]) ^ gmul(8'h09, t[4*c + (r+3)%4]);
        end else begin
          m[r + 4*c] = gmul(8'h02, t[4*c + r]) ^ gmul(8'h03, t[4*c + (r+1)%4])
                     ^ t[4*c + (r+2)%4] ^ t[4*c + (r+3)%4];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (first_i) begin
        state_o[127-8*i -: 8] = s[i] ^ k[i];
      end else if (last_i) begin
        state_o[127-8*i -: 8] = t[i] ^ k[i];
      end else if (inv_i) begin
        state_o[127-8*i -: 8] = m[i];
      end else begin
        state_o[127-8*i -: 8] = m[i] ^ k[i];
      end
    end
  end
endmodule

// ===== src/aes128_block_cipher.sv =====
// AES-128 block cipher top level: key expansion sequencer, round-key RAMs
// and shared round unit. Depends on aes_pkg, aes_ram, aes_round.
//
// Usage: write key_high (index 0) and key_low (index 1) through cfg_we_i.
// A write while idle starts a key expansion, during which busy_o is high;
// after reset the all-zero key is expanded the same way.
// An item is taken when start_i is high and busy_o and cfg_we_i are low.
// The item runs through one shared round unit, one round per cycle: the initial key
// addition and ten rounds, each reading one round key from the RAMs.
// The block is loaded when the item is taken; the key read is registered.
// The result appears on result_high_o/result_low_o with done_o high for
// exactly one cycle; the next item can be taken while done_o is high.
// The receiver cannot stall; results must be taken when done_o is high.
// Reset clears the control state and starts expansion of the zero key.
`timescale 1ns / 1ps
module aes128_block_cipher
  import aes_pkg::*;
#(
  parameter int unsigned NumRounds = Rounds
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        start_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  input  logic        decrypt_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o
);
  localparam int unsigned NWords = 4 * (NumRounds + 1);
  localparam int unsigned Depth = NWords / 2;
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned WW = $clog2(NWords + 1);
  localparam int unsigned RW = $clog2(NumRounds + 2);

  state_e state_q, state_d;
  logic [63:0] key_hi_q, key_lo_q;
  logic [127:0] win_q, win_d;
  logic [7:0] rcon_q, rcon_d;
  logic [WW-1:0] wcnt_q, wcnt_d;
  logic [RW-1:0] rnd_q, rnd_d;
  logic [127:0] st_q, st_d;
  logic inv_q, inv_d;
  logic done_q, done_d;
  logic [31:0] tw, nw;
  logic [127:0] win_next;
  logic ram_we, lo_phase_q, lo_phase_d;
  logic [AW-1:0] waddr, raddr_hi, raddr_lo, waddr_hi;
  logic [63:0] wdata, rd_hi, rd_lo, wdata_hi;
  logic init_wr;
  logic [127:0] rnd_out;
  logic [RW-1:0] kidx;
  logic accept;

  assign accept = start_i && !busy_o && !cfg_we_i;

  // Key expansion: one new word per cycle, held while a pair of words is written to the RAM.
  always_comb begin
    tw = win_q[31:0];
    if (wcnt_q[1:0] == 2'd0) begin
      tw = sub_word({tw[23:0], tw[31:24]}) ^ {rcon_q, 24'h0};
    end
    nw = win_q[127:96] ^ tw;
    win_next = {win_q[95:0], nw};
  end

  assign ram_we = (state_q == ST_EXPAND) && lo_phase_q;
  assign waddr = AW'((wcnt_q - WW'(2)) >> 1);
  assign wdata = win_q[63:0];
  // The first write also stores the first half of round key zero.
  assign init_wr = (wcnt_q == WW'(4));
  assign waddr_hi = init_wr ? '0 : waddr;
  assign wdata_hi = init_wr ? win_q[127:64] : wdata;
  assign kidx = inv_q ? RW'(NumRounds) - rnd_q : rnd_q;
  assign raddr_hi = AW'({kidx, 1'b0});
  assign raddr_lo = AW'({kidx, 1'b1});

  aes_ram #(.Width(64), .Depth(Depth)) u_ram_hi (
    .clk_i, .we_i(ram_we && (init_wr || !waddr[0])), .waddr_i(waddr_hi),
    .wdata_i(wdata_hi), .raddr_i(raddr_hi), .rdata_o(rd_hi)
  );
  aes_ram #(.Width(64), .Depth(Depth)) u_ram_lo (
    .clk_i, .we_i(ram_we && waddr[0]), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr_lo), .rdata_o(rd_lo)
  );

  logic [RW-1:0] proc_q;
  logic pvalid_q;

  aes_round u_round (
    .state_i(st_q), .key_i({rd_hi, rd_lo}), .inv_i(inv_q),
    .first_i(proc_q == '0), .last_i(proc_q == RW'(NumRounds)), .state_o(rnd_out)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cfg_we_i) state_d = ST_EXPAND;
        else if (start_i) state_d = ST_RUN;
      end
      ST_EXPAND: begin
        if (wcnt_q == WW'(NWords) && !lo_phase_q) state_d = ST_IDLE;
      end
      ST_RUN: begin
        if (pvalid_q && proc_q == RW'(NumRounds)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    win_d = win_q;
    rcon_d = rcon_q;
    wcnt_d = wcnt_q;
    lo_phase_d = 1'b0;
    rnd_d = rnd_q;
    st_d = st_q;
    inv_d = inv_q;
    done_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cfg_we_i) begin
          win_d = cfg_index_i[0] ? {key_hi_q, cfg_wdata_i} : {cfg_wdata_i, key_lo_q};
          wcnt_d = WW'(4);
          rcon_d = 8'h01;
          lo_phase_d = 1'b1;
        end else if (start_i) begin
          st_d = {block_high_i, block_low_i};
          inv_d = decrypt_i;
          rnd_d = '0;
        end
      end
      ST_EXPAND: begin
        lo_phase_d = 1'b1;
        if (wcnt_q != WW'(NWords) || lo_phase_q) begin
          if (lo_phase_q) begin
            lo_phase_d = 1'b0;
          end else begin
            win_d = win_next;
            wcnt_d = wcnt_q + WW'(1);
            if (wcnt_q[1:0] == 2'd0) rcon_d = xtime(rcon_q);
            lo_phase_d = (wcnt_q[0] == 1'b1);
          end
        end
      end
      ST_RUN: begin
        if (rnd_q != RW'(NumRounds)) rnd_d = rnd_q + RW'(1);
        if (pvalid_q) st_d = rnd_out;
        if (pvalid_q && proc_q == RW'(NumRounds)) done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EXPAND;
      key_hi_q <= '0;
      key_lo_q <= '0;
      win_q <= '0;
      rcon_q <= 8'h01;
      wcnt_q <= WW'(4);
      lo_phase_q <= 1'b1;
      rnd_q <= '0;
      inv_q <= 1'b0;
      done_q <= 1'b0;
      proc_q <= '0;
      pvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i[0]) key_lo_q <= cfg_wdata_i;
        else key_hi_q <= cfg_wdata_i;
      end
      win_q <= win_d;
      rcon_q <= rcon_d;
      wcnt_q <= wcnt_d;
      lo_phase_q <= lo_phase_d;
      rnd_q <= rnd_d;
      inv_q <= inv_d;
      done_q <= done_d;
      proc_q <= (state_q == ST_RUN) ? rnd_q : '0;
      pvalid_q <= (state_q == ST_RUN) && !(pvalid_q && proc_q == RW'(NumRounds));
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign result_high_o = st_q[127:64];
  assign result_low_o = st_q[63:0];

  `include "aes128_block_cipher_assert.svh"

  `AES_ASSERT_CLK(a_done_idle, done_o |-> !busy_o)
  `AES_ASSERT_CLK(a_accept_run, accept |=> state_q == ST_RUN)
  `AES_ASSERT_NEVER(a_write_in_run, ram_we && state_q == ST_RUN)
endmodule

// ===== verif/aes_tb_pkg.sv =====
// Register indexes shared by the AES-128 testbench files.
// No dependencies.
`timescale 1ns / 1ps
package aes_tb_pkg;
  localparam logic [0:0] KeyHighIdx = 1'b0;
  localparam logic [0:0] KeyLowIdx  = 1'b1;
endpackage

// ===== verif/aes128_checker.sv =====
// Checker for the AES-128 block cipher: tracks the key, predicts each result
// block and compares it with the block output. Depends on aes_tb_pkg.
`timescale 1ns / 1ps
module aes128_checker
  import aes_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        start_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  input  logic        decrypt_i,
  input  logic        busy_i,
  input  logic        done_i,
  input  logic [63:0] result_high_i,
  input  logic [63:0] result_low_i,
  output int          fail_count_o,
  output int          pending_o
);
  logic [7:0]   sbox_fwd [256];
  logic [7:0]   sbox_inv [256];
  logic [127:0] rkeys [11];
  logic [63:0]  key_hi;
  logic [63:0]  key_lo;
  logic [127:0] expected_blocks [$];
  int           fails = 0;
  int           pend = 0;

  function automatic logic [7:0] gf_dbl(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ a;
      a = gf_dbl(a);
    end
    return acc;
  endfunction

  function automatic logic [7:0] gf_inv(logic [7:0] x);
    logic [7:0] acc;
    logic [7:0] p;
    acc = 8'h01;
    p = x;
    for (int i = 1; i < 8; i++) begin
      p = gf_mul(p, p);
      acc = gf_mul(acc, p);
    end
    return acc;
  endfunction

  function automatic logic [7:0] rot8(logic [7:0] x, int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [127:0] sub_all(logic [127:0] s, logic inv);
    logic [7:0] b;
    for (int i = 0; i < 16; i++) begin
      b = s[127-8*i -: 8];
      s[127-8*i -: 8] = inv ? sbox_inv[b] : sbox_fwd[b];
    end
    return s;
  endfunction

  function automatic logic [127:0] shift_all(logic [127:0] s, logic inv);
    logic [127:0] t;
    int src;
    int dst;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = r + 4 * ((c + r) & 3);
        dst = r + 4 * c;
        if (inv) t[127-8*src -: 8] = s[127-8*dst -: 8];
        else t[127-8*dst -: 8] = s[127-8*src -: 8];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_all(logic [127:0] s, logic inv);
    logic [7:0] col [4];
    logic [7:0] coef [4];
    logic [7:0] v;
    if (inv) begin
      coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    end else begin
      coef = '{8'h02, 8'h03, 8'h01, 8'h01};
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) col[r] = s[127-8*(r+4*c) -: 8];
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) v = v ^ gf_mul(coef[(k - r) & 3], col[k]);
        s[127-8*(r+4*c) -: 8] = v;
      end
    end
    return s;
  endfunction

  task automatic expand_round_keys();
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    w[0] = key_hi[63:32];
    w[1] = key_hi[31:0];
    w[2] = key_lo[63:32];
    w[3] = key_lo[31:0];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if ((i & 3) == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sbox_fwd[t[31:24]], sbox_fwd[t[23:16]], sbox_fwd[t[15:8]], sbox_fwd[t[7:0]]};
        t[31:24] = t[31:24] ^ rc;
        rc = gf_dbl(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) rkeys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endtask

  function automatic logic [127:0] aes_transform(logic [127:0] s, logic inv);
    if (!inv) begin
      s = s ^ rkeys[0];
      for (int r = 1; r < 10; r++) s = mix_all(shift_all(sub_all(s, 1'b0), 1'b0), 1'b0)
                                       ^ rkeys[r];
      s = shift_all(sub_all(s, 1'b0), 1'b0) ^ rkeys[10];
    end else begin
      s = s ^ rkeys[10];
      for (int r = 9; r >= 1; r--) s = mix_all(sub_all(shift_all(s, 1'b1), 1'b1)
                                               ^ rkeys[r], 1'b1);
      s = sub_all(shift_all(s, 1'b1), 1'b1) ^ rkeys[0];
    end
    return s;
  endfunction

  initial begin
    logic [7:0] v;
    for (int i = 0; i < 256; i++) begin
      v = gf_inv(8'(i));
      sbox_fwd[i] = v ^ rot8(v, 1) ^ rot8(v, 2) ^ rot8(v, 3) ^ rot8(v, 4) ^ 8'h63;
      v = 8'(i);
      sbox_inv[i] = gf_inv(rot8(v, 1) ^ rot8(v, 3) ^ rot8(v, 6) ^ 8'h05);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    logic [127:0] exp_blk;
    if (!rst_ni) begin
      key_hi = '0;
      key_lo = '0;
      expand_round_keys();
      expected_blocks.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == KeyHighIdx) key_hi = cfg_wdata_i;
        else key_lo = cfg_wdata_i;
        expand_round_keys();
      end
      if (start_i && !busy_i && !cfg_we_i) begin
        expected_blocks.push_back(aes_transform({block_high_i, block_low_i}, decrypt_i));
      end
      if (done_i) begin
        if (expected_blocks.size() == 0) begin
          $error("result with no item outstanding: %h %h", result_high_i, result_low_i);
          fails++;
        end else begin
          exp_blk = expected_blocks.pop_front();
          if (result_high_i !== exp_blk[127:64]) begin
            $error("result_high expected %h actual %h", exp_blk[127:64], result_high_i);
            fails++;
          end
          if (result_low_i !== exp_blk[63:0]) begin
            $error("result_low expected %h actual %h", exp_blk[63:0], result_low_i);
            fails++;
          end
        end
      end
    end
    pend = expected_blocks.size();
  end

  assign fail_count_o = fails;
  assign pending_o = pend;
endmodule

// ===== verif/tb_aes128_block_cipher.sv =====
// Testbench top for the AES-128 block cipher: drives keys and blocks with
// random gaps and gives the verdict. Depends on aes_tb_pkg and aes128_checker.
`timescale 1ns / 1ps
module tb_aes128_block_cipher;
  import aes_tb_pkg::*;

  localparam int CycleLimit = 300000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = KeyHighIdx;
  logic [63:0] cfg_wdata = '0;
  logic        start = 1'b0;
  logic [63:0] block_high = '0;
  logic [63:0] block_low = '0;
  logic        decrypt = 1'b0;
  logic        busy;
  logic        done;
  logic [63:0] result_high;
  logic [63:0] result_low;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  logic        gaps_on = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  aes128_block_cipher u_dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata), .start_i(start), .block_high_i(block_high),
    .block_low_i(block_low), .decrypt_i(decrypt), .busy_o(busy), .done_o(done),
    .result_high_o(result_high), .result_low_o(result_low)
  );

  aes128_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata), .start_i(start), .block_high_i(block_high),
    .block_low_i(block_low), .decrypt_i(decrypt), .busy_i(busy), .done_i(done),
    .result_high_i(result_high), .result_low_i(result_low),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic wait_idle();
    @(posedge clk);
    while (busy || pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [63:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_key(logic [63:0] hi, logic [63:0] lo);
    write_reg(KeyHighIdx, hi);
    write_reg(KeyLowIdx, lo);
    wait_idle();
  endtask

  task automatic send_block(logic [63:0] hi, logic [63:0] lo, logic dec);
    start <= 1'b1;
    block_high <= hi;
    block_low <= lo;
    decrypt <= dec;
    do @(posedge clk); while (busy);
    if (gaps_on && $urandom_range(0, 99) < 34) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic finish_burst();
    start <= 1'b0;
    wait_idle();
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [63:0] hi;
    logic [63:0] lo;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // Power-up all-zero key, then the standard example key.
    send_block('0, '0, 1'b0);
    send_block('1, '1, 1'b1);
    finish_burst();
    set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1);
    send_block('0, '0, 1'b1);
    send_block('1, '1, 1'b0);
    send_block(64'h8000000000000000, 64'h0000000000000001, 1'b0);
    finish_burst();
    set_key('1, '1);
    send_block('0, '0, 1'b0);
    send_block('1, '1, 1'b0);
    send_block('0, '1, 1'b1);
    send_block('1, '0, 1'b1);
    finish_burst();
    set_key('1, '0);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
    finish_burst();

    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 3) set_key('0, '0);
      else set_key(rand64(), rand64());
      for (int i = 0; i < 400; i++) begin
        gaps_on = !(phase == 1 && i >= 100 && i < 300);
        case ($urandom_range(0, 9))
          0: begin
            hi = '0;
            lo = '1;
          end
          1: begin
            hi = '1;
            lo = rand64();
          end
          default: begin
            hi = rand64();
            lo = rand64();
          end
        endcase
        send_block(hi, lo, 1'($urandom_range(0, 1)));
        if (i == 200) finish_burst();
      end
      finish_burst();
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
